FILE: rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache block.
// Used by lfu_entry_store and lfu_cache_lookup_insert; depends on nothing.
`default_nettype none

package lfu_pkg;

    // Default sizing of the cache.
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths.
    localparam int COUNT_W   = 32;  // saturating use counter
    localparam int CAP_W     = 5;   // capacity register
    localparam int OUT_W     = 32;  // read_value and evicted_key ports
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Register index, taken from the word address paddr[PADDR_W-1:2].
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    // Operation codes.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Per-array write enables of the entry store.
    typedef struct packed {
        logic key;
        logic val;
        logic cnt;
        logic rank;
    } lfu_wr_en_t;

endpackage

`default_nettype wire

FILE: rtl/lfu_cache_lookup_insert.sv
// Top level of the fully associative LFU cache with LRU tie breaking.
// Holds the sequencer, the shared compare unit and the APB register; uses lfu_pkg
// and instantiates lfu_entry_store.
`default_nettype none

// Each transfer on the op channel is a get (mode 0) or a put (mode 1) of a key, and
// each one produces exactly one transfer on the res channel. The entries live in one
// storage block with a single read port, so a sequencer walks the n entries in use
// one per cycle: a search pass that finds the matching key and the eviction victim
// (lowest use count, least recently used among equals), then, for hits and inserts,
// a second pass that ages the recency ranks, followed by one write of the touched
// entry. The number n of entries in use is at most ENTRIES; op_ready is high only
// between items. A finished result sits in the output register until taken, and the
// next op transfer is accepted meanwhile. Entries in use always occupy the lowest
// indices, so a fill count marks them and no clearing pass is needed after reset.
// The capacity register (byte address 0) may only be written while the block is
// idle; values above ENTRIES act as ENTRIES, and zero makes every put a no-op.
// Lowering capacity below the fill level drops nothing: a later put of a new key
// replaces one entry.
module lfu_cache_lookup_insert
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic      [PDATA_W-1:0]    prdata,
    output logic                       pready,
    // operation channel
    input  wire logic                  op_valid,
    output logic                       op_ready,
    input  wire logic                  mode,
    input  wire logic [KEY_BITS-1:0]   key,
    input  wire logic [VALUE_BITS-1:0] value,
    // result channel
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       found,
    output logic      [OUT_W-1:0]      read_value,
    output logic                       evicted,
    output logic      [OUT_W-1:0]      evicted_key
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RANK,
        S_WRITE,
        S_DONE
    } state_t;

    state_t state_reg;

    // Configuration and fill level.
    logic [CAP_W-1:0]      capacity_reg;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      eff_cap;

    // Current item.
    logic                  mode_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      step_reg;

    // Search results.
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [IDX_W-1:0]      hit_rank_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic                  vic_vld_reg;
    logic [IDX_W-1:0]      vic_idx_reg;
    logic [COUNT_W-1:0]    vic_cnt_reg;
    logic [IDX_W-1:0]      vic_rank_reg;
    logic [KEY_BITS-1:0]   vic_key_reg;

    // Update plan.
    logic [IDX_W-1:0]      target_reg;
    logic [CNT_W-1:0]      pivot_reg;
    logic [COUNT_W-1:0]    new_cnt_reg;
    logic                  new_key_reg;
    logic                  write_val_reg;

    // Pending result and output register.
    logic                  res_found_reg;
    logic [OUT_W-1:0]      res_read_reg;
    logic                  res_evicted_reg;
    logic [OUT_W-1:0]      res_evkey_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg;
    logic [OUT_W-1:0]      out_read_reg;
    logic                  out_evicted_reg;
    logic [OUT_W-1:0]      out_evkey_reg;

    // Storage interface.
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [COUNT_W-1:0]    rd_cnt;
    logic [IDX_W-1:0]      rd_rank;
    logic [IDX_W-1:0]      wr_addr;
    lfu_wr_en_t            wr_en;
    logic [IDX_W-1:0]      wr_rank;

    // Shared compare unit, fed by the entry read in the previous cycle.
    logic [IDX_W-1:0]      proc_idx;
    logic                  proc_vld;
    logic                  key_match;
    logic                  vic_better;
    logic                  rank_older;
    logic [COUNT_W-1:0]    hit_cnt_inc;
    logic                  evict_now;
    logic                  cfg_write;

    lfu_entry_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .rd_cnt  (rd_cnt),
        .rd_rank (rd_rank),
        .wr_addr (wr_addr),
        .wr_en   (wr_en),
        .wr_key  (key_reg),
        .wr_val  (val_reg),
        .wr_cnt  (new_cnt_reg),
        .wr_rank (wr_rank)
    );

    assign eff_cap = (32'(capacity_reg) > 32'(ENTRIES)) ? ENTRIES_CNT
                                                        : CNT_W'(capacity_reg);

    // Both passes issue the read of entry step and process entry step - 1.
    assign proc_idx = IDX_W'(step_reg - CNT_W'(1));
    assign proc_vld = (step_reg != '0);
    assign rd_addr  = (step_reg < n_reg) ? step_reg[IDX_W-1:0] : '0;

    assign key_match  = (rd_key == key_reg);
    assign vic_better = !vic_vld_reg || (rd_cnt < vic_cnt_reg) ||
                        ((rd_cnt == vic_cnt_reg) && (rd_rank > vic_rank_reg));
    assign rank_older = (proc_idx != target_reg) && (CNT_W'(rd_rank) < pivot_reg);

    assign hit_cnt_inc = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + COUNT_W'(1);

    // A put of a new key into a cache at or above its nonzero capacity replaces the victim.
    assign evict_now = (mode_reg == MODE_PUT) && (eff_cap != '0) && !hit_reg &&
                       (n_reg >= eff_cap);

    // Storage writes: aging ranks, then the touched entry's count, rank, new key/value.
    always_comb
    begin
        wr_en   = '0;
        wr_addr = target_reg;
        wr_rank = '0;
        unique case (state_reg)
            S_RANK:
            begin
                if (proc_vld && rank_older)
                begin
                    wr_en.rank = 1'b1;
                    wr_addr    = proc_idx;
                    wr_rank    = rd_rank + IDX_W'(1);
                end
            end
            S_WRITE:
            begin
                wr_en.key  = new_key_reg;
                wr_en.val  = write_val_reg;
                wr_en.cnt  = 1'b1;
                wr_en.rank = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            capacity_reg    <= CAP_RESET;
            used_reg        <= '0;
            mode_reg        <= MODE_GET;
            key_reg         <= '0;
            val_reg         <= '0;
            n_reg           <= '0;
            step_reg        <= '0;
            hit_reg         <= 1'b0;
            hit_idx_reg     <= '0;
            hit_cnt_reg     <= '0;
            hit_rank_reg    <= '0;
            hit_val_reg     <= '0;
            vic_vld_reg     <= 1'b0;
            vic_idx_reg     <= '0;
            vic_cnt_reg     <= '0;
            vic_rank_reg    <= '0;
            vic_key_reg     <= '0;
            target_reg      <= '0;
            pivot_reg       <= '0;
            new_cnt_reg     <= '0;
            new_key_reg     <= 1'b0;
            write_val_reg   <= 1'b0;
            res_found_reg   <= 1'b0;
            res_read_reg    <= '0;
            res_evicted_reg <= 1'b0;
            res_evkey_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_read_reg    <= '0;
            out_evicted_reg <= 1'b0;
            out_evkey_reg   <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[PADDR_W-1:2] == REG_CAPACITY))
            begin
                capacity_reg <= pwdata[CAP_W-1:0];
            end

            // A result taken while a new one is loaded is handled in S_DONE.
            if (out_valid_reg && res_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (op_valid)
                    begin
                        mode_reg    <= mode;
                        key_reg     <= key;
                        val_reg     <= value;
                        n_reg       <= used_reg;
                        step_reg    <= '0;
                        hit_reg     <= 1'b0;
                        vic_vld_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (proc_vld)
                    begin
                        // Keys are unique among entries in use, so one match at most.
                        if (key_match)
                        begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= proc_idx;
                            hit_cnt_reg  <= rd_cnt;
                            hit_rank_reg <= rd_rank;
                            hit_val_reg  <= rd_val;
                        end
                        if (vic_better)
                        begin
                            vic_vld_reg  <= 1'b1;
                            vic_idx_reg  <= proc_idx;
                            vic_cnt_reg  <= rd_cnt;
                            vic_rank_reg <= rd_rank;
                            vic_key_reg  <= rd_key;
                        end
                    end
                    step_reg <= step_reg + CNT_W'(1);
                    if (step_reg == n_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    res_found_reg   <= hit_reg;
                    res_read_reg    <= ((mode_reg == MODE_GET) && hit_reg)
                                       ? OUT_W'(hit_val_reg) : '0;
                    res_evicted_reg <= evict_now;
                    res_evkey_reg   <= evict_now ? OUT_W'(vic_key_reg) : '0;
                    step_reg        <= '0;
                    if (mode_reg == MODE_GET)
                    begin
                        if (hit_reg)
                        begin
                            target_reg    <= hit_idx_reg;
                            pivot_reg     <= CNT_W'(hit_rank_reg);
                            new_cnt_reg   <= hit_cnt_inc;
                            new_key_reg   <= 1'b0;
                            write_val_reg <= 1'b0;
                            state_reg     <= S_RANK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else if (eff_cap == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (hit_reg)
                    begin
                        target_reg    <= hit_idx_reg;
                        pivot_reg     <= CNT_W'(hit_rank_reg);
                        new_cnt_reg   <= hit_cnt_inc;
                        new_key_reg   <= 1'b0;
                        write_val_reg <= 1'b1;
                        state_reg     <= S_RANK;
                    end
                    else if (n_reg >= eff_cap)
                    begin
                        // Removing the victim and inserting at the front ages exactly
                        // the entries that were newer than the victim.
                        target_reg    <= vic_idx_reg;
                        pivot_reg     <= CNT_W'(vic_rank_reg);
                        new_cnt_reg   <= COUNT_W'(1);
                        new_key_reg   <= 1'b1;
                        write_val_reg <= 1'b1;
                        state_reg     <= S_RANK;
                    end
                    else
                    begin
                        // Fill the first free slot; every entry in use ages by one.
                        target_reg    <= n_reg[IDX_W-1:0];
                        pivot_reg     <= n_reg;
                        new_cnt_reg   <= COUNT_W'(1);
                        new_key_reg   <= 1'b1;
                        write_val_reg <= 1'b1;
                        used_reg      <= used_reg + CNT_W'(1);
                        state_reg     <= S_RANK;
                    end
                end

                S_RANK:
                begin
                    step_reg <= step_reg + CNT_W'(1);
                    if (step_reg == n_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                end

                S_WRITE:
                begin
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || res_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_found_reg   <= res_found_reg;
                        out_read_reg    <= res_read_reg;
                        out_evicted_reg <= res_evicted_reg;
                        out_evkey_reg   <= res_evkey_reg;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign op_ready    = (state_reg == S_IDLE);
    assign res_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign read_value  = out_read_reg;
    assign evicted     = out_evicted_reg;
    assign evicted_key = out_evkey_reg;

    // The fill level never exceeds the number of entries.
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= ENTRIES_CNT)
        else $error("fill level exceeds entry count");

    // An accepted operation keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && op_ready) |=> !op_ready)
        else $error("operation channel ready right after a transfer");

    // Eviction only happens on a put miss.
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(evicted && found))
        else $error("eviction reported together with a hit");

    // A nonzero read value only comes from a get hit.
    a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (read_value != '0)) |-> (found && !evicted))
        else $error("read value reported without a hit");

endmodule

`default_nettype wire

FILE: rtl/lfu_entry_store.sv
// Entry storage of the LFU cache: key, value, use count and recency rank arrays.
// One shared write address and one read address with registered read data; uses lfu_pkg.
`default_nettype none

module lfu_entry_store
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  wire logic                                   clk,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output logic      [KEY_BITS-1:0]                    rd_key,
    output logic      [VALUE_BITS-1:0]                  rd_val,
    output logic      [COUNT_W-1:0]                     rd_cnt,
    output logic      [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_rank,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  wire lfu_wr_en_t                             wr_en,
    input  wire logic [KEY_BITS-1:0]                    wr_key,
    input  wire logic [VALUE_BITS-1:0]                  wr_val,
    input  wire logic [COUNT_W-1:0]                     wr_cnt,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_rank
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
    logic [COUNT_W-1:0]    cnt_mem  [ENTRIES];
    logic [IDX_W-1:0]      rank_mem [ENTRIES];

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [COUNT_W-1:0]    rd_cnt_reg;
    logic [IDX_W-1:0]      rd_rank_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_en.val)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (wr_en.cnt)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (wr_en.rank)
        begin
            rank_mem[wr_addr] <= wr_rank;
        end
    end

    // The read data is registered; the controller only uses data of written entries.
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[rd_addr];
        rd_val_reg  <= val_mem[rd_addr];
        rd_cnt_reg  <= cnt_mem[rd_addr];
        rd_rank_reg <= rank_mem[rd_addr];
    end

    assign rd_key  = rd_key_reg;
    assign rd_val  = rd_val_reg;
    assign rd_cnt  = rd_cnt_reg;
    assign rd_rank = rd_rank_reg;

endmodule

`default_nettype wire
